FILE: rtl/gpg_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, payload types and controller/datapath signal groups.
package gpg_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Field widths
  localparam int SIZE_W       = 7;
  localparam int COUNT_W      = 16;
  localparam int GEN_W        = 16;
  localparam int PKT_W        = 16;
  localparam int SLOT_FIELD_W = 6;

  // Remainder unit operand widths: generation index times base size
  localparam int DIVIDEND_W = GEN_W + SIZE_W;
  localparam int DIVISOR_W  = COUNT_W;

  // Parameter defaults
  localparam int DEF_MAX_GEN_SIZE      = 64;
  localparam int DEF_PACKET_INDEX_BITS = 16;

  // Scheme constants: rotation step and look-back offset of the extra slots
  localparam int ROT_STEP  = 7;
  localparam int GEN_BACK  = 7;

  // Register indexes
  typedef enum logic [1:0] {
    REG_BASE_SIZE,
    REG_GEN_SIZE,
    REG_NUM_PACKETS,
    REG_NUM_GENERATIONS
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  base_size;
    logic [SIZE_W-1:0]  gen_size;
    logic [COUNT_W-1:0] num_packets;
    logic [COUNT_W-1:0] num_generations;
  } cfg_t;

  // Channel payloads
  typedef struct packed {
    logic [GEN_W-1:0] gen_index;
  } in_item_t;

  typedef struct packed {
    logic [PKT_W-1:0]        packet_index;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    last_slot;
  } out_item_t;

  // Operand selection of the shared remainder unit
  typedef enum logic [1:0] {
    DIV_ROT,
    DIV_BASE,
    DIV_WRAP,
    DIV_EXTRA
  } div_sel_t;

  typedef struct packed {
    logic     load_gen;
    logic     clr_slot;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_rot;
    logic     start_direct;
    logic     start_wrap;
    logic     start_fix;
    logic     cap_cand;
    logic     probe_next;
    logic     cap_result;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_zero;
    logic base_slot;
    logic gen_ge_back;
    logic div_done;
    logic hit;
    logic probe_last;
    logic last_slot;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/gpg_stream_if.sv
`timescale 1ns / 1ps
// Interface: valid/ready stream channel with a typed payload.
interface gpg_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

FILE: rtl/gpg_cfg.sv
`timescale 1ns / 1ps
// Configuration register file behind an APB-style port.
module gpg_cfg
  import gpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_BASE_SIZE:       cfg_nxt.base_size       = pwdata[SIZE_W-1:0];
        REG_GEN_SIZE:        cfg_nxt.gen_size        = pwdata[SIZE_W-1:0];
        REG_NUM_PACKETS:     cfg_nxt.num_packets     = pwdata[COUNT_W-1:0];
        REG_NUM_GENERATIONS: cfg_nxt.num_generations = pwdata[COUNT_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (idx)
      REG_BASE_SIZE:       prdata = CFG_DATA_W'(cfg_r.base_size);
      REG_GEN_SIZE:        prdata = CFG_DATA_W'(cfg_r.gen_size);
      REG_NUM_PACKETS:     prdata = CFG_DATA_W'(cfg_r.num_packets);
      REG_NUM_GENERATIONS: prdata = CFG_DATA_W'(cfg_r.num_generations);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_size       <= SIZE_W'(1);
      cfg_r.gen_size        <= SIZE_W'(1);
      cfg_r.num_packets     <= COUNT_W'(1);
      cfg_r.num_generations <= COUNT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/gpg_div.sv
`timescale 1ns / 1ps
// Restoring remainder unit: one dividend bit per cycle.
module gpg_div
  import gpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;

  // Shift the next dividend bit into the partial remainder and subtract if it fits
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/gpg_dp.sv
`timescale 1ns / 1ps
// Datapath: candidate arithmetic, chosen-packet lanes, duplicate search and output register.
module gpg_dp
  import gpg_pkg::*;
#(
  parameter int MAX_GEN_SIZE      = DEF_MAX_GEN_SIZE,
  parameter int PACKET_INDEX_BITS = DEF_PACKET_INDEX_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic [GEN_W-1:0] gen_index,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  localparam int SLOT_W    = $clog2(MAX_GEN_SIZE);
  localparam int GRP_SIZE  = 8;
  localparam int NGRP      = (MAX_GEN_SIZE + GRP_SIZE - 1) / GRP_SIZE;
  localparam int BACK_W    = SIZE_W + 1;
  localparam int GEN7_W    = GEN_W + 3;
  localparam int MASK_BITS = (PACKET_INDEX_BITS < PKT_W) ? PACKET_INDEX_BITS : PKT_W;
  localparam logic [PKT_W-1:0] PKT_MASK = {PKT_W{1'b1}} >> (PKT_W - MASK_BITS);

  // Request and per-slot registers
  logic [GEN_W-1:0]      gen_r, gen_nxt;
  logic [DIVIDEND_W-1:0] prod_gen_r, prod_start_r;
  logic [GEN_W-1:0]      start_r, start_nxt;
  logic [SIZE_W-1:0]     rot_r, rot_nxt;
  logic [PKT_W-1:0]      cand_r, cand_nxt;
  logic [PKT_W-1:0]      probe_r, probe_nxt;
  logic [PKT_W-1:0]      res_r, res_nxt;
  logic [SLOT_W-1:0]     j_r, j_nxt;
  logic [SLOT_W-1:0]     t_r, t_nxt;
  logic [PKT_W-1:0]      chosen_r [MAX_GEN_SIZE];
  logic [NGRP-1:0]       grp_r, grp_nxt;
  out_item_t             out_r, out_nxt;
  logic                  ovalid_r, ovalid_nxt;

  // Derived values
  logic [SIZE_W-1:0]          g_eff;
  logic [SIZE_W-1:0]          nbase;
  logic [SIZE_W-1:0]          j_ext;
  logic [BACK_W-1:0]          back;
  logic [BACK_W-1:0]          wrap_diff;
  logic [SIZE_W-1:0]          jb;
  logic [BACK_W-1:0]          rsum;
  logic [BACK_W-1:0]          rt;
  logic [GEN7_W-1:0]          gen7;
  logic [PKT_W:0]             probe_inc;
  logic [NGRP*GRP_SIZE-1:0]   match;
  logic                       last;

  // Remainder unit connections
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIVISOR_W-1:0]  div_rem;

  // Slot count capped at the lane count; base slots capped at the slot count
  assign g_eff = (cfg.gen_size > SIZE_W'(MAX_GEN_SIZE)) ? SIZE_W'(MAX_GEN_SIZE) : cfg.gen_size;
  assign nbase = (cfg.base_size < g_eff) ? cfg.base_size : g_eff;
  assign j_ext = SIZE_W'(j_r);

  // Look-back distance of an extra slot and the wrapped shortfall when it passes zero
  assign back      = BACK_W'(j_ext) + BACK_W'(GEN_BACK) - BACK_W'(cfg.base_size);
  assign wrap_diff = back - gen_r[BACK_W-1:0];

  // Rotated offset within the generation; both terms lie below the slot count
  assign jb   = j_ext - cfg.base_size;
  assign rsum = BACK_W'(jb) + BACK_W'(rot_r);
  assign rt   = (rsum >= BACK_W'(g_eff)) ? rsum - BACK_W'(g_eff) : rsum;

  assign gen7      = GEN7_W'(gen_r) * GEN7_W'(ROT_STEP);
  assign probe_inc = {1'b0, probe_r} + (PKT_W + 1)'(1);
  assign last      = ((BACK_W'(j_ext) + BACK_W'(1)) == BACK_W'(g_eff));

  // Operand selection for the shared remainder unit
  always_comb begin
    case (cmd.div_sel)
      DIV_ROT: begin
        div_dividend = DIVIDEND_W'(gen7);
        div_divisor  = DIVISOR_W'(g_eff);
      end
      DIV_BASE: begin
        div_dividend = prod_gen_r + DIVIDEND_W'(j_r);
        div_divisor  = cfg.num_packets;
      end
      DIV_WRAP: begin
        div_dividend = DIVIDEND_W'(wrap_diff);
        div_divisor  = cfg.num_generations;
      end
      DIV_EXTRA: begin
        div_dividend = prod_start_r + DIVIDEND_W'(rt);
        div_divisor  = cfg.num_packets;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = cfg.num_packets;
      end
    endcase
  end

  gpg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Compare the probe against every lane already filled in this generation
  always_comb begin
    match = '0;
    for (int k = 0; k < MAX_GEN_SIZE; k++) begin
      match[k] = (SLOT_W'(k) < j_r) && (chosen_r[k] == probe_r);
    end
  end

  // First level of the registered OR tree
  always_comb begin
    for (int n = 0; n < NGRP; n++) begin
      grp_nxt[n] = |match[n*GRP_SIZE +: GRP_SIZE];
    end
  end

  // Register updates under controller command
  always_comb begin
    gen_nxt    = gen_r;
    start_nxt  = start_r;
    rot_nxt    = rot_r;
    cand_nxt   = cand_r;
    probe_nxt  = probe_r;
    res_nxt    = res_r;
    j_nxt      = j_r;
    t_nxt      = t_r;
    out_nxt    = out_r;
    ovalid_nxt = ovalid_r && !out_ready;

    if (cmd.load_gen) begin
      gen_nxt = gen_index;
    end
    if (cmd.clr_slot) begin
      j_nxt = '0;
    end
    if (cmd.cap_rot) begin
      rot_nxt = SIZE_W'(div_rem);
    end
    if (cmd.start_direct) begin
      start_nxt = gen_r - GEN_W'(back);
    end
    if (cmd.start_wrap) begin
      start_nxt = (div_rem == '0) ? '0 : cfg.num_generations - div_rem;
    end
    // The earlier generation never coincides with the requested one
    if (cmd.start_fix && (start_r == gen_r)) begin
      start_nxt = start_r + GEN_W'(1);
    end
    if (cmd.cap_cand) begin
      cand_nxt  = div_rem;
      probe_nxt = div_rem;
      t_nxt     = '0;
    end
    if (cmd.probe_next) begin
      probe_nxt = (probe_inc == {1'b0, cfg.num_packets}) ? '0 : probe_inc[PKT_W-1:0];
      t_nxt     = t_r + SLOT_W'(1);
    end
    // With no free packet left the unstepped candidate is reused
    if (cmd.cap_result) begin
      res_nxt = (|grp_r) ? cand_r : probe_r;
    end
    if (cmd.emit) begin
      out_nxt.packet_index = res_r & PKT_MASK;
      out_nxt.slot         = SLOT_FIELD_W'(j_r);
      out_nxt.last_slot    = last;
      ovalid_nxt           = 1'b1;
      j_nxt                = j_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      j_r      <= '0;
      t_r      <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      j_r      <= j_nxt;
      t_r      <= t_nxt;
    end
    gen_r        <= gen_nxt;
    prod_gen_r   <= DIVIDEND_W'(gen_r) * DIVIDEND_W'(cfg.base_size);
    prod_start_r <= DIVIDEND_W'(start_r) * DIVIDEND_W'(cfg.base_size);
    start_r      <= start_nxt;
    rot_r        <= rot_nxt;
    cand_r       <= cand_nxt;
    probe_r      <= probe_nxt;
    res_r        <= res_nxt;
    grp_r        <= grp_nxt;
    out_r        <= out_nxt;
    if (cmd.emit) begin
      chosen_r[j_r] <= res_r;
    end
  end

  // Status back to the controller
  assign status.cfg_zero    = (cfg.gen_size == '0) || (cfg.num_packets == '0) ||
                              (cfg.num_generations == '0);
  assign status.base_slot   = (j_ext < nbase);
  assign status.gen_ge_back = (gen_r >= GEN_W'(back));
  assign status.div_done    = div_done;
  assign status.hit         = |grp_r;
  assign status.probe_last  = (t_r == j_r);
  assign status.last_slot   = last;
  assign status.out_free    = !ovalid_r || out_ready;

  assign out_valid = ovalid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/gpg_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the per-slot steps of one generation request.
module gpg_ctrl
  import gpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ROT_WAIT,
    S_SLOT,
    S_WRAP_WAIT,
    S_FIX,
    S_MUL,
    S_XDIV,
    S_CAND_WAIT,
    S_PROBE,
    S_PROBE_CHK,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd          = '0;
    cmd.div_sel  = DIV_ROT;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load_gen = 1'b1;
          in_ready_nxt = 1'b0;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.clr_slot = 1'b1;
        if (status.cfg_zero) begin
          in_ready_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_ROT;
          state_nxt     = S_ROT_WAIT;
        end
      end
      S_ROT_WAIT: begin
        if (status.div_done) begin
          cmd.cap_rot = 1'b1;
          state_nxt   = S_SLOT;
        end
      end
      S_SLOT: begin
        if (status.base_slot) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_BASE;
          state_nxt     = S_CAND_WAIT;
        end else if (status.gen_ge_back) begin
          cmd.start_direct = 1'b1;
          state_nxt        = S_FIX;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_WRAP;
          state_nxt     = S_WRAP_WAIT;
        end
      end
      S_WRAP_WAIT: begin
        if (status.div_done) begin
          cmd.start_wrap = 1'b1;
          state_nxt      = S_FIX;
        end
      end
      S_FIX: begin
        cmd.start_fix = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_XDIV;
      end
      S_XDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_EXTRA;
        state_nxt     = S_CAND_WAIT;
      end
      S_CAND_WAIT: begin
        if (status.div_done) begin
          cmd.cap_cand = 1'b1;
          state_nxt    = S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (!status.hit || status.probe_last) begin
          cmd.cap_result = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PROBE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_slot) begin
            in_ready_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_SLOT;
          end
        end
      end
      default: begin
        in_ready_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

FILE: rtl/generation_packet_grouper.sv
`timescale 1ns / 1ps
// Top level: generation packet grouper with configuration registers.
//
// For each accepted generation index the block returns one transfer per slot of the
// generation, slot 0 first, carrying the packet index placed there and a flag on the final
// slot. Registers sit at byte addresses 0x0 (base_size), 0x4 (gen_size), 0x8 (num_packets)
// and 0xC (num_generations) and may only be written while no request is in progress. One
// request is handled at a time: the rotation is computed first, then each slot in turn, where an
// extra slot first works out the earlier generation it borrows from and every packet already
// chosen that has to be stepped over adds a probe step. Each value is worked out by the shared
// remainder unit, which resolves one of its 23 dividend bits per cycle. The next request is
// accepted as soon as the final result of the current one has been placed in the output
// register. If gen_size, num_packets or num_generations is zero, a request produces no
// results.
module generation_packet_grouper
  import gpg_pkg::*;
#(
  parameter int MAX_GEN_SIZE      = DEF_MAX_GEN_SIZE,
  parameter int PACKET_INDEX_BITS = DEF_PACKET_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gpg_stream_if.sink            in_ch,
  gpg_stream_if.source          out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_item;

  gpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gpg_dp #(
    .MAX_GEN_SIZE      (MAX_GEN_SIZE),
    .PACKET_INDEX_BITS (PACKET_INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .gen_index (in_ch.data.gen_index),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

endmodule

FILE: rtl/gpg_checker.sv
`timescale 1ns / 1ps
// Checker on the top-level ports, bound to the grouper.
module gpg_checker
  import gpg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  logic [SLOT_FIELD_W-1:0] exp_slot_r, exp_slot_nxt;

  // Slot expected on the next result transfer
  always_comb begin
    exp_slot_nxt = exp_slot_r;
    if (out_valid && out_ready) begin
      exp_slot_nxt = out_item.last_slot ? '0 : out_item.slot + SLOT_FIELD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_slot_r <= '0;
    end else begin
      exp_slot_r <= exp_slot_nxt;
    end
  end

  // A request holds the input off for at least the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready still high after a transfer");

  // Results of a generation appear in slot order, restarting after the final slot
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.slot == exp_slot_r)
    else $error("result slot out of sequence");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind generation_packet_grouper gpg_checker u_gpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.data)
);

FILE: sim/generation_packet_grouper_checker.sv
`timescale 1ns / 1ps
// Checker: follows register writes, predicts each generation's packet list and compares results.
module generation_packet_grouper_checker
  import gpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int MAX_SLOTS = DEF_MAX_GEN_SIZE;
  localparam int PKT_BITS  = DEF_PACKET_INDEX_BITS;
  localparam int REPORT_MAX = 10;

  // Shadow copy of the registers, kept in step with the configuration port.
  logic [SIZE_W-1:0]  base_size;
  logic [SIZE_W-1:0]  gen_size;
  logic [COUNT_W-1:0] num_packets;
  logic [COUNT_W-1:0] num_generations;

  // Slot results still owed by the block, oldest first.
  out_item_t pending_slots[$];

  // Works out the full packet list of one generation and queues it slot by slot.
  function automatic void predict_generation(input logic [GEN_W-1:0] gen_in);
    longint unsigned gen, slots, bsz, npk, ngn, rotate, back, earlier, r, cand, probe;
    longint unsigned taken[MAX_SLOTS];
    int total, nbase, j, t, k;
    bit found, dup;
    out_item_t item;
    gen = gen_in;
    bsz = base_size;
    npk = num_packets;
    ngn = num_generations;
    if (gen_size == 0 || npk == 0 || ngn == 0) return;
    slots = (gen_size > MAX_SLOTS) ? MAX_SLOTS : gen_size;
    total = int'(slots);
    nbase = (bsz < slots) ? int'(bsz) : total;
    rotate = (ROT_STEP * gen) % slots;
    for (j = 0; j < total; j++) begin
      if (j < nbase) begin
        cand = (gen * bsz + j) % npk;
      end else begin
        // Extra slots borrow from an earlier generation, wrapping below zero.
        back = longint'(j) + GEN_BACK - bsz;
        if (gen >= back) begin
          earlier = gen - back;
        end else begin
          r = (back - gen) % ngn;
          earlier = (r == 0) ? 0 : ngn - r;
        end
        if (earlier == gen) earlier++;
        cand = (earlier * bsz + ((longint'(j) - bsz + rotate) % slots)) % npk;
      end
      // Step past packets already in this generation; keep the candidate if none is free.
      probe = cand;
      found = 0;
      for (t = 0; t <= j && !found; t++) begin
        dup = 0;
        for (k = 0; k < j; k++) begin
          if (taken[k] == probe) dup = 1;
        end
        if (!dup) begin
          cand = probe;
          found = 1;
        end else begin
          probe = (probe + 1) % npk;
        end
      end
      taken[j] = cand & 64'hFFFF;
      item.packet_index = PKT_W'(cand & ((64'd1 << PKT_BITS) - 1));
      item.slot = SLOT_FIELD_W'(j);
      item.last_slot = (j + 1 == total);
      pending_slots.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      base_size <= 1;
      gen_size <= 1;
      num_packets <= 1;
      num_generations <= 1;
      pending_slots.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      // Register writes complete on the access cycle.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_BASE_SIZE:       base_size <= pwdata[SIZE_W-1:0];
          REG_GEN_SIZE:        gen_size <= pwdata[SIZE_W-1:0];
          REG_NUM_PACKETS:     num_packets <= pwdata[COUNT_W-1:0];
          REG_NUM_GENERATIONS: num_generations <= pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) predict_generation(in_data.gen_index);

      // Each result transfer is matched against the oldest owed slot.
      if (out_valid && out_ready) begin
        if (pending_slots.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: unexpected result: packet %0d slot %0d last %0b", $realtime,
                     out_data.packet_index, out_data.slot, out_data.last_slot);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_slots.pop_front();
          if (out_data.packet_index !== want.packet_index || out_data.slot !== want.slot ||
              out_data.last_slot !== want.last_slot) begin
            if (mismatches < REPORT_MAX)
              $display("%0t: mismatch: expected packet %0d slot %0d last %0b, got %0d %0d %0b",
                       $realtime, want.packet_index, want.slot, want.last_slot,
                       out_data.packet_index, out_data.slot, out_data.last_slot);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= pending_slots.size();
    end
  end

endmodule

FILE: sim/generation_packet_grouper_test.sv
`timescale 1ns / 1ps
// Testbench top: drives generation requests and register writes and reports the verdict.
module generation_packet_grouper_test;
  import gpg_pkg::*;

  localparam int HOLD_CYCLES   = 600;
  localparam int IDLE_LIMIT    = 60000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 270;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;
  int                    idle_cycles;
  bit                    tx_gaps_on;
  bit                    rx_gaps_on;
  bit                    rx_hold_req;

  gpg_stream_if #(.payload_t(in_item_t))  in_ch ();
  gpg_stream_if #(.payload_t(out_item_t)) out_ch ();

  generation_packet_grouper dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  generation_packet_grouper_checker slot_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stop the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls per transfer, with one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready <= 0;
    forever begin
      if (rx_hold_req) begin
        gap = HOLD_CYCLES;
        rx_hold_req = 0;
      end else begin
        gap = rx_gaps_on ? $urandom_range(0, 8) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Lower valid once the last request has gone and wait for every owed result.
  task automatic wait_drained();
    in_ch.valid <= 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Registers change only with the block idle; a request with no results may still be busy.
  task automatic configure(input int bsz, input int gsz, input int npk, input int ngn);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_BASE_SIZE, bsz);
    write_reg(REG_GEN_SIZE, gsz);
    write_reg(REG_NUM_PACKETS, npk);
    write_reg(REG_NUM_GENERATIONS, ngn);
  endtask

  task automatic send_gen(input int gen);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data <= in_item_t'(gen[GEN_W-1:0]);
    in_ch.valid <= 1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  initial begin
    int bsz, gsz, npk, ngn, n, gen, phase, random_done, pick;
    bit no_results;
    rst_n <= 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 0;
    in_ch.data <= '0;
    tx_gaps_on = 1;
    rx_gaps_on = 1;
    rx_hold_req = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset values: one slot, one packet; also a generation beyond the range.
    send_gen(0);
    send_gen(65535);

    // Extra slots reaching below generation zero, and requests beyond the range.
    configure(4, 10, 100, 20);
    send_gen(0);
    send_gen(19);
    send_gen(25);
    send_gen(65535);

    // The earlier generation wraps onto the request itself and is advanced.
    configure(2, 6, 50, 7);
    send_gen(3);

    // Zero sizes give no results.
    configure(3, 0, 100, 20);
    send_gen(5);
    configure(3, 5, 0, 20);
    send_gen(5);
    configure(3, 5, 100, 0);
    send_gen(5);

    // Generation size above the slot limit is capped.
    configure(3, 127, 1000, 300);
    send_gen(5);

    // Base size above the generation size, and no base slots at all.
    configure(100, 8, 500, 50);
    send_gen(7);
    configure(0, 5, 40, 10);
    send_gen(2);

    // More slots than packets: no free packet is left to step to.
    configure(2, 12, 5, 4);
    send_gen(1);
    send_gen(3);

    // Widest register values.
    configure(127, 64, 65535, 65535);
    send_gen(65535);
    send_gen(0);
    configure(1, 64, 65535, 65535);
    send_gen(43690);

    // Random phases: a fresh register setting, then a burst of requests.
    phase = 0;
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      bsz = (pick == 0) ? 0 : (pick < 7) ? $urandom_range(1, 8) :
            (pick < 9) ? $urandom_range(9, 32) : $urandom_range(33, 127);
      pick = $urandom_range(0, 19);
      gsz = (pick == 0 && phase > 5) ? 0 : (pick < 15) ? $urandom_range(1, 12) :
            (pick < 19) ? $urandom_range(13, 32) : $urandom_range(33, 127);
      pick = $urandom_range(0, 19);
      npk = (pick == 0 && phase > 5) ? 0 : (pick < 6) ? $urandom_range(1, 20) :
            (pick < 13) ? $urandom_range(21, 2000) : $urandom_range(2001, 65535);
      pick = $urandom_range(0, 19);
      ngn = (pick == 0 && phase > 5) ? 0 : (pick < 10) ? $urandom_range(1, 40) :
            $urandom_range(41, 65535);
      // Keep the collision search short on long generations.
      if (gsz > 12 && npk < gsz) npk = gsz + $urandom_range(0, 100);
      no_results = (gsz == 0 || npk == 0 || ngn == 0);
      n = no_results ? 3 : (gsz > 32) ? 3 : $urandom_range(8, 30);

      configure(bsz, gsz, npk, ngn);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      // One phase holds the result side back so the block backs up into its input.
      if (phase == 2) rx_hold_req = 1;

      for (int i = 0; i < n; i++) begin
        // Once, the sender pauses until every owed result has arrived.
        if (phase == 4 && i == n / 2) wait_drained();
        if (ngn > 0 && $urandom_range(0, 3) != 0) gen = $urandom_range(0, ngn - 1);
        else gen = $urandom_range(0, 65535);
        send_gen(gen);
        if (!no_results) random_done++;
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
